@@ rtl/mrrm_pkg.sv @@
package mrrm_pkg;

    localparam int MAX_REGS    = 8;
    localparam int RESULT_CAP  = 8;
    localparam int MAX_FRAME   = 256;
    localparam int MIN_FRAME   = 5;
    localparam int HEADER_LEN  = 3;
    localparam int REG_IDX_W   = $clog2(MAX_REGS);
    localparam int TOTAL_W     = $clog2(MAX_FRAME + 1);
    localparam int COUNT_W     = 4;
    localparam int CNT_W       = (REG_IDX_W > 3) ? REG_IDX_W : 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;

    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [7:0]  SLAVE_ADDR_INIT = 8'h01;
    localparam int          EXC_FLAG_BIT    = 7;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_REG    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_INVALID   = 3'd2,
        ST_CRC       = 3'd3,
        ST_LENGTH    = 3'd4,
        ST_EXCEPTION = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        JOB_REQUEST,
        JOB_REGS,
        JOB_STATUS
    } job_kind_t;

    typedef enum logic {
        PH_IDLE,
        PH_RECV
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_REQ,
        B_REGS,
        B_STATUS
    } back_state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         function_code;
        logic [15:0]        start_register;
        logic [COUNT_W-1:0] register_count;
        logic [7:0]         rx_byte;
    } in_item_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [7:0]         slave;
        logic [7:0]         func;
        logic [15:0]        start;
        logic [COUNT_W-1:0] count;
        status_t            status;
        logic [7:0]         exc;
    } job_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        status_t     status;
        logic [7:0]  exception_code;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic regs_done;
    } back_status_t;

    typedef logic [MAX_REGS-1:0][15:0] reg_store_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/mrrm_queue.sv @@
module mrrm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mrrm_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output mrrm_pkg::job_t pop_job,
    output logic           empty
);
    import mrrm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/mrrm_front.sv @@
module mrrm_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mrrm_pkg::in_item_t     in_item,
    output logic                   q_push,
    output mrrm_pkg::job_t         q_job,
    input  logic                   q_full,
    input  mrrm_pkg::back_status_t back_status,
    output mrrm_pkg::reg_store_t   reg_store
);
    import mrrm_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         slave_addr_reg;
    logic [15:0]        cbt_reg, cbt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [7:0]         resp_slave_reg, resp_slave_next;
    logic [7:0]         resp_func_reg, resp_func_next;
    logic [7:0]         resp_len_reg, resp_len_next;
    logic [15:0]        trail_reg, trail_next;
    logic [7:0]         want_func_reg, want_func_next;
    logic [COUNT_W-1:0] want_count_reg, want_count_next;
    logic [7:0]         high_reg, high_next;
    logic               regs_pending_reg, regs_pending_next;
    reg_store_t         store_reg;

    logic                 accept;
    logic                 store_we;
    logic [REG_IDX_W-1:0] store_idx;
    logic [TOTAL_W-1:0]   data_off;
    logic [TOTAL_W-2:0]   data_idx;
    logic [15:0]          byte_cbt;
    logic [15:0]          byte_trail;
    logic [TOTAL_W-1:0]   byte_total;
    logic                 byte_done;
    logic [TOTAL_W-1:0]   fin_total;
    logic [15:0]          fin_cbt;
    logic [15:0]          fin_trail;
    job_t                 fin_job;
    job_t                 req_job;

    // the register data is read by the back end, so hold new items while it is emitted
    assign in_ready  = !q_full && !regs_pending_reg;
    assign accept    = in_valid && in_ready;
    assign reg_store = store_reg;

    // per-byte update of the frame tracking
    always_comb begin
        byte_total = total_reg + TOTAL_W'(1);
        byte_trail = {trail_reg[7:0], in_item.rx_byte};
        byte_cbt   = (total_reg >= TOTAL_W'(2)) ? crc_fold(cbt_reg, trail_reg[15:8]) : cbt_reg;
        data_off   = total_reg - TOTAL_W'(HEADER_LEN);
        data_idx   = data_off[TOTAL_W-1:1];
        byte_done  = (byte_total >= TOTAL_W'(MIN_FRAME)) &&
                     (resp_func_reg[EXC_FLAG_BIT] ||
                      byte_total >= TOTAL_W'(resp_len_reg) + TOTAL_W'(MIN_FRAME));
    end

    // frame-end checks, in priority order
    always_comb begin
        if (in_item.op == OP_BYTE) begin
            fin_total = byte_total;
            fin_cbt   = byte_cbt;
            fin_trail = byte_trail;
        end else begin
            fin_total = total_reg;
            fin_cbt   = cbt_reg;
            fin_trail = trail_reg;
        end
        fin_job        = '0;
        fin_job.kind   = JOB_STATUS;
        fin_job.count  = want_count_reg;
        fin_job.status = ST_OK;
        if (fin_total < TOTAL_W'(MIN_FRAME)) begin
            fin_job.status = ST_TIMEOUT;
        end else if (resp_slave_reg != slave_addr_reg || resp_func_reg != want_func_reg) begin
            if (resp_func_reg[EXC_FLAG_BIT]) begin
                fin_job.status = ST_EXCEPTION;
                fin_job.exc    = resp_len_reg;
            end else begin
                fin_job.status = ST_INVALID;
            end
        end else if (fin_cbt != {fin_trail[7:0], fin_trail[15:8]}) begin
            fin_job.status = ST_CRC;
        end else if (resp_len_reg != {3'b000, want_count_reg, 1'b0} ||
                     {4'b0000, want_count_reg} > 8'(MAX_REGS) ||
                     {4'b0000, want_count_reg} > 8'(RESULT_CAP)) begin
            fin_job.status = ST_LENGTH;
        end else if (want_count_reg != '0) begin
            fin_job.kind = JOB_REGS;
        end
    end

    always_comb begin
        req_job       = '0;
        req_job.kind  = JOB_REQUEST;
        req_job.slave = slave_addr_reg;
        req_job.func  = in_item.function_code;
        req_job.start = in_item.start_register;
        req_job.count = in_item.register_count;
    end

    always_comb begin
        phase_next      = phase_reg;
        cbt_next        = cbt_reg;
        total_next      = total_reg;
        resp_slave_next = resp_slave_reg;
        resp_func_next  = resp_func_reg;
        resp_len_next   = resp_len_reg;
        trail_next      = trail_reg;
        want_func_next  = want_func_reg;
        want_count_next = want_count_reg;
        high_next       = high_reg;
        q_push          = 1'b0;
        q_job           = fin_job;
        store_we        = 1'b0;
        store_idx       = data_idx[REG_IDX_W-1:0];

        if (accept) begin
            case (in_item.op)
                OP_START: begin
                    q_push          = 1'b1;
                    q_job           = req_job;
                    want_func_next  = in_item.function_code;
                    want_count_next = in_item.register_count;
                    cbt_next        = CRC_INIT;
                    total_next      = '0;
                    resp_slave_next = '0;
                    resp_func_next  = '0;
                    resp_len_next   = '0;
                    trail_next      = '0;
                    high_next       = '0;
                    phase_next      = PH_RECV;
                end
                OP_BYTE: begin
                    if (phase_reg == PH_RECV && total_reg < TOTAL_W'(MAX_FRAME)) begin
                        cbt_next   = byte_cbt;
                        trail_next = byte_trail;
                        total_next = byte_total;
                        if (total_reg == TOTAL_W'(0)) begin
                            resp_slave_next = in_item.rx_byte;
                        end else if (total_reg == TOTAL_W'(1)) begin
                            resp_func_next = in_item.rx_byte;
                        end else if (total_reg == TOTAL_W'(2)) begin
                            resp_len_next = in_item.rx_byte;
                        end else if (!data_off[0]) begin
                            high_next = in_item.rx_byte;
                        end else begin
                            store_we = ({1'b0, data_idx} < TOTAL_W'(MAX_REGS));
                        end
                        if (byte_done) begin
                            q_push     = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                OP_TIMEOUT: begin
                    if (phase_reg == PH_RECV) begin
                        q_push     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end

        if (q_push && q_job.kind == JOB_REGS) begin
            regs_pending_next = 1'b1;
        end else if (back_status.regs_done) begin
            regs_pending_next = 1'b0;
        end else begin
            regs_pending_next = regs_pending_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            slave_addr_reg   <= SLAVE_ADDR_INIT;
            cbt_reg          <= CRC_INIT;
            total_reg        <= '0;
            resp_slave_reg   <= '0;
            resp_func_reg    <= '0;
            resp_len_reg     <= '0;
            trail_reg        <= '0;
            want_func_reg    <= '0;
            want_count_reg   <= '0;
            high_reg         <= '0;
            regs_pending_reg <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            if (cfg_we) begin
                slave_addr_reg <= cfg_wdata;
            end
            cbt_reg          <= cbt_next;
            total_reg        <= total_next;
            resp_slave_reg   <= resp_slave_next;
            resp_func_reg    <= resp_func_next;
            resp_len_reg     <= resp_len_next;
            trail_reg        <= trail_next;
            want_func_reg    <= want_func_next;
            want_count_reg   <= want_count_next;
            high_reg         <= high_next;
            regs_pending_reg <= regs_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[store_idx] <= {high_reg, in_item.rx_byte};
        end
    end

endmodule

@@ rtl/mrrm_back.sv @@
module mrrm_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  mrrm_pkg::job_t         q_job,
    output logic                   q_pop,
    input  mrrm_pkg::reg_store_t   reg_store,
    output mrrm_pkg::back_status_t back_status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mrrm_pkg::out_item_t    out_item
);
    import mrrm_pkg::*;

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      crc_reg, crc_next;
    logic             valid_reg, valid_next;
    out_item_t        out_reg, out_next;

    logic       load;
    logic [7:0] req_byte;
    logic       regs_last;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = out_reg;
    assign regs_last = (COUNT_W'(cnt_reg) + COUNT_W'(1)) == job_reg.count;

    always_comb begin
        case (cnt_reg[2:0])
            3'd0:    req_byte = job_reg.slave;
            3'd1:    req_byte = job_reg.func;
            3'd2:    req_byte = job_reg.start[15:8];
            3'd3:    req_byte = job_reg.start[7:0];
            3'd4:    req_byte = 8'h00;
            3'd5:    req_byte = {4'h0, job_reg.count};
            3'd6:    req_byte = crc_reg[7:0];
            default: req_byte = crc_reg[15:8];
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        job_next    = job_reg;
        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        valid_next  = load ? 1'b0 : valid_reg;
        out_next    = out_reg;
        q_pop       = 1'b0;
        back_status = '0;

        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    cnt_next = '0;
                    crc_next = CRC_INIT;
                    case (q_job.kind)
                        JOB_REQUEST: state_next = B_REQ;
                        JOB_REGS:    state_next = B_REGS;
                        default:     state_next = B_STATUS;
                    endcase
                end
            end
            B_REQ: begin
                if (load) begin
                    valid_next   = 1'b1;
                    out_next     = '0;
                    out_next.kind    = KIND_TX;
                    out_next.tx_byte = req_byte;
                    out_next.status  = ST_OK;
                    out_next.last    = (cnt_reg[2:0] == 3'd7);
                    // crc runs over the six header bytes as they go out
                    if (cnt_reg[2:0] < 3'd6) begin
                        crc_next = crc_fold(crc_reg, req_byte);
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg[2:0] == 3'd7) begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_REGS: begin
                if (load) begin
                    valid_next         = 1'b1;
                    out_next           = '0;
                    out_next.kind      = KIND_REG;
                    out_next.reg_index = cnt_reg[2:0];
                    out_next.reg_value = reg_store[cnt_reg[REG_IDX_W-1:0]];
                    out_next.status    = ST_OK;
                    out_next.last      = regs_last;
                    cnt_next           = cnt_reg + CNT_W'(1);
                    if (regs_last) begin
                        back_status.regs_done = 1'b1;
                        state_next            = B_IDLE;
                    end
                end
            end
            B_STATUS: begin
                if (load) begin
                    valid_next              = 1'b1;
                    out_next                = '0;
                    out_next.kind           = KIND_STATUS;
                    out_next.status         = job_reg.status;
                    out_next.exception_code = job_reg.exc;
                    out_next.last           = 1'b1;
                    state_next              = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        cnt_reg <= cnt_next;
        crc_reg <= crc_next;
        out_reg <= out_next;
    end

endmodule

@@ rtl/modbus_rtu_read_master_unit.sv @@
// channel | dir | tdata fields (low bit up)                                   | tuser | tlast
// s_      | in  | function_code, start_register, register_count, rx_byte     | op    | -
// m_      | out | tx_byte, reg_index, reg_value, status, exception_code       | kind  | last
// cfg     | in  | slave_address, written when cfg_we is high                  | -     | -
//
// the front end folds each received byte into the crc and hands finished work to a
// two-entry job queue. the back end pops a job and then gives one result per cycle while
// the output is not stalled: a start item gives eight request bytes, a register run one
// result per register, a status job one. input stalls when the queue is full and while
// register results are being sent. synchronous reset, no clearing pass.
module modbus_rtu_read_master_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [7:0]                          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // function_code, start_register, register_count, rx_byte, zero pad
    input  logic [mrrm_pkg::IN_DATA_W-1:0]      s_tdata,
    // op
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tx_byte, reg_index, reg_value, status, exception_code, zero pad
    output logic [mrrm_pkg::OUT_DATA_W-1:0]     m_tdata,
    // kind
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);
    import mrrm_pkg::*;

    in_item_t     in_item;
    job_t         push_job;
    job_t         pop_job;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;
    back_status_t back_status;
    reg_store_t   reg_store;
    out_item_t    out_item;

    assign in_item.op             = s_tuser;
    assign in_item.function_code  = s_tdata[7:0];
    assign in_item.start_register = s_tdata[23:8];
    assign in_item.register_count = s_tdata[27:24];
    assign in_item.rx_byte        = s_tdata[35:28];

    mrrm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (in_item),
        .q_push      (q_push),
        .q_job       (push_job),
        .q_full      (q_full),
        .back_status (back_status),
        .reg_store   (reg_store)
    );

    mrrm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    mrrm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .reg_store   (reg_store),
        .back_status (back_status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_item    (out_item)
    );

    assign m_tdata = {2'b00, out_item.exception_code, out_item.status, out_item.reg_value,
                      out_item.reg_index, out_item.tx_byte};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

endmodule

@@ bench/tb_modbus_rtu_read_master_unit.sv @@
module tb_modbus_rtu_read_master_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mrrm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [7:0]            cfg_wdata = 8'h00;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = 2'd0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    modbus_rtu_read_master_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // mirror of the master's state
    logic [7:0]  dev_addr = SLAVE_ADDR_INIT;
    phase_t      rx_state = PH_IDLE;
    logic [15:0] crc_body = CRC_INIT;
    logic [15:0] tail16 = 16'h0000;
    int          nbytes = 0;
    logic [7:0]  hdr_slave = 8'h00;
    logic [7:0]  hdr_func = 8'h00;
    logic [7:0]  hdr_len = 8'h00;
    logic [7:0]  hi_pend = 8'h00;
    logic [7:0]  req_func = 8'h00;
    logic [3:0]  req_count = 4'd0;
    logic [15:0] reg_copy [MAX_REGS];

    out_item_t   owed_results [$];
    in_item_t    pend_items [$];
    in_item_t    held;
    out_item_t   due;
    logic [7:0]  fr [$];

    int send_idle = 0;
    int recv_stall = 0;
    int queued = 0;
    int errors = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic owe_result(input kind_t k, input logic [7:0] tx, input logic [2:0] idx,
                              input logic [15:0] val, input status_t st,
                              input logic [7:0] exc, input logic lst);
        out_item_t r;
        r.kind = k;
        r.tx_byte = tx;
        r.reg_index = idx;
        r.reg_value = val;
        r.status = st;
        r.exception_code = exc;
        r.last = lst;
        owed_results.push_back(r);
    endtask

    task automatic close_frame();
        logic [15:0] sent_crc;
        status_t     st;
        rx_state = PH_IDLE;
        sent_crc = {tail16[7:0], tail16[15:8]};
        st = ST_OK;
        if (nbytes < MIN_FRAME) begin
            owe_result(KIND_STATUS, 8'h00, 3'd0, 16'h0000, ST_TIMEOUT, 8'h00, 1'b1);
        end else if (hdr_slave != dev_addr || hdr_func != req_func) begin
            if (hdr_func[EXC_FLAG_BIT])
                owe_result(KIND_STATUS, 8'h00, 3'd0, 16'h0000, ST_EXCEPTION, hdr_len, 1'b1);
            else
                owe_result(KIND_STATUS, 8'h00, 3'd0, 16'h0000, ST_INVALID, 8'h00, 1'b1);
        end else if (crc_body != sent_crc) begin
            owe_result(KIND_STATUS, 8'h00, 3'd0, 16'h0000, ST_CRC, 8'h00, 1'b1);
        end else begin
            if (int'(hdr_len) != 2 * int'(req_count) || int'(req_count) > MAX_REGS)
                st = ST_LENGTH;
            if (st != ST_OK || req_count == 0) begin
                owe_result(KIND_STATUS, 8'h00, 3'd0, 16'h0000, st, 8'h00, 1'b1);
            end else begin
                for (int k = 0; k < int'(req_count); k++)
                    owe_result(KIND_REG, 8'h00, k[2:0], reg_copy[k], ST_OK, 8'h00,
                               k == int'(req_count) - 1);
            end
        end
    endtask

    task automatic take_rx(input logic [7:0] b);
        int i;
        i = nbytes;
        // bytes past the frame buffer are dropped without effect
        if (i < MAX_FRAME) begin
            if (i >= 2)
                crc_body = crc16_byte(crc_body, tail16[15:8]);
            tail16 = {tail16[7:0], b};
            if (i == 0)
                hdr_slave = b;
            else if (i == 1)
                hdr_func = b;
            else if (i == 2)
                hdr_len = b;
            else if (((i - HEADER_LEN) % 2) == 0)
                hi_pend = b;
            else if ((i - HEADER_LEN) / 2 < MAX_REGS)
                reg_copy[(i - HEADER_LEN) / 2] = {hi_pend, b};
            nbytes = i + 1;
            if (nbytes >= MIN_FRAME &&
                (hdr_func[EXC_FLAG_BIT] || nbytes >= MIN_FRAME + int'(hdr_len)))
                close_frame();
        end
    endtask

    task automatic mirror_master(input in_item_t it);
        logic [7:0]  req [8];
        logic [15:0] c;
        if (it.op == OP_START) begin
            req_func = it.function_code;
            req_count = it.register_count;
            req[0] = dev_addr;
            req[1] = it.function_code;
            req[2] = it.start_register[15:8];
            req[3] = it.start_register[7:0];
            req[4] = 8'h00;
            req[5] = {4'h0, it.register_count};
            c = CRC_INIT;
            for (int k = 0; k < 6; k++)
                c = crc16_byte(c, req[k]);
            req[6] = c[7:0];
            req[7] = c[15:8];
            crc_body = CRC_INIT;
            tail16 = 16'h0000;
            nbytes = 0;
            hdr_slave = 8'h00;
            hdr_func = 8'h00;
            hdr_len = 8'h00;
            hi_pend = 8'h00;
            rx_state = PH_RECV;
            for (int k = 0; k < 8; k++)
                owe_result(KIND_TX, req[k], 3'd0, 16'h0000, ST_OK, 8'h00, k == 7);
        end else if (it.op == OP_BYTE) begin
            if (rx_state == PH_RECV)
                take_rx(it.rx_byte);
        end else if (it.op == OP_TIMEOUT) begin
            if (rx_state == PH_RECV)
                close_frame();
        end
    endtask

    // sender: predicts each item as it is taken, then presents the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 2'd0;
        end else begin
            if (s_tvalid && s_tready)
                mirror_master(held);
            if (!s_tvalid || s_tready) begin
                if (pend_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    held = pend_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(IN_DATA_W - 36){1'b0}}, held.rx_byte, held.register_count,
                                held.start_register, held.function_code};
                    s_tuser <= held.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        end
    endtask

    // receiver: compares each result with the oldest one owed
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result expected none got kind %0d data 0x%h last %0d",
                             $time, m_tuser, m_tdata, m_tlast);
                end else begin
                    due = owed_results.pop_front();
                    check_field("kind", due.kind, m_tuser);
                    check_field("tx_byte", due.tx_byte, m_tdata[7:0]);
                    check_field("reg_index", due.reg_index, m_tdata[10:8]);
                    check_field("reg_value", due.reg_value, m_tdata[26:11]);
                    check_field("status", due.status, m_tdata[29:27]);
                    check_field("exception_code", due.exception_code, m_tdata[37:30]);
                    check_field("last", due.last, m_tlast);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic [7:0] fc,
                              input logic [15:0] sr, input logic [3:0] rc,
                              input logic [7:0] rb);
        in_item_t it;
        it.op = op;
        it.function_code = fc;
        it.start_register = sr;
        it.register_count = rc;
        it.rx_byte = rb;
        pend_items.push_back(it);
        queued++;
    endtask

    task automatic queue_start(input logic [7:0] fc, input logic [15:0] sr,
                               input logic [3:0] rc);
        queue_item(OP_START, fc, sr, rc, 8'($urandom));
    endtask

    task automatic queue_rx(input logic [7:0] b);
        queue_item(OP_BYTE, 8'($urandom), 16'($urandom), 4'($urandom), b);
    endtask

    task automatic queue_timeout();
        queue_item(OP_TIMEOUT, 8'($urandom), 16'($urandom), 4'($urandom), 8'($urandom));
    endtask

    task automatic queue_frame(input int n);
        for (int i = 0; i < n && i < fr.size(); i++)
            queue_rx(fr[i]);
    endtask

    task automatic build_reply(input logic [7:0] addr, input logic [7:0] fc,
                               input logic [7:0] len, input int ndata);
        fr.delete();
        fr.push_back(addr);
        fr.push_back(fc);
        fr.push_back(len);
        repeat (ndata) fr.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic seal_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (fr[i])
            c = crc16_byte(c, fr[i]);
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
    endtask

    // one request followed by a reply, mostly well formed, sometimes after a stray item
    task automatic gen_transaction();
        logic [7:0] fc;
        logic [3:0] rc;
        logic [7:0] flip;
        int         len;
        int         pick;
        flip = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 9) == 0)
            queue_item(2'($urandom_range(1, 3)), 8'($urandom), 16'($urandom), 4'($urandom),
                       8'($urandom));
        pick = $urandom_range(0, 9);
        fc = (pick < 4) ? 8'd3 : (pick < 7) ? 8'd4 : 8'($urandom_range(0, 255));
        rc = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
        queue_start(fc, 16'($urandom_range(0, 65535)), rc);
        build_reply(dev_addr, fc, 8'(2 * rc), 2 * rc);
        seal_crc();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                queue_frame(fr.size());
            end
            4: begin
                // exception reply, sometimes from a foreign slave
                build_reply(($urandom_range(0, 3) == 0) ? 8'($urandom) : dev_addr,
                            fc | 8'h80, 8'($urandom), 0);
                seal_crc();
                queue_frame(fr.size());
            end
            5: begin
                len = $urandom_range(0, fr.size() - 1);
                fr[len] = fr[len] ^ flip;
                queue_frame(fr.size());
                queue_timeout();
            end
            6: begin
                len = $urandom_range(0, 20);
                if (len == 2 * rc)
                    len++;
                build_reply(dev_addr, fc, 8'(len), len);
                seal_crc();
                queue_frame(fr.size());
                queue_timeout();
            end
            7: begin
                if ($urandom_range(0, 1) == 0)
                    fr[0] = fr[0] ^ flip;
                else
                    fr[1] = fr[1] ^ flip;
                queue_frame(fr.size());
                queue_timeout();
            end
            8: begin
                queue_frame($urandom_range(0, fr.size() - 1));
                queue_timeout();
            end
            default: begin
                // left open, the next request abandons it
                queue_frame($urandom_range(0, fr.size() - 1));
            end
        endcase
    endtask

    task automatic wait_quiet();
        do @(negedge aclk);
        while (pend_items.size() != 0 || s_tvalid || owed_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_slave(input logic [7:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        dev_addr = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int snd, input int stl, input int target,
                              input bit mid_pause);
        bit paused;
        paused = 1'b0;
        send_idle = snd;
        recv_stall = stl;
        queued = 0;
        while (queued < target) begin
            gen_transaction();
            if (mid_pause && !paused && queued >= target / 2) begin
                wait_quiet();
                paused = 1'b1;
            end
        end
        wait_quiet();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // idle inputs, then a full eight register read that fills the whole store
        queue_rx(8'hFF);
        queue_timeout();
        queue_item(OP_UNUSED, 8'hFF, 16'hFFFF, 4'hF, 8'hFF);
        queue_start(8'd3, 16'hFFFF, 4'd8);
        build_reply(dev_addr, 8'd3, 8'd16, 16);
        fr[3] = 8'h00;
        fr[4] = 8'hFF;
        fr[5] = 8'hFF;
        fr[6] = 8'h00;
        seal_crc();
        queue_frame(fr.size());
        queue_start(8'h00, 16'h0000, 4'd0);
        queue_timeout();
        queue_start(8'd4, 16'h1234, 4'd2);
        build_reply(dev_addr, 8'h84, 8'h02, 0);
        seal_crc();
        queue_frame(fr.size());
        wait_quiet();

        set_slave(8'hFF);
        run_random(0, 0, 30, 1'b0);
        set_slave(8'h00);
        run_random(50, 0, 30, 1'b0);
        set_slave(8'($urandom_range(1, 254)));
        run_random(0, 50, 30, 1'b1);
        set_slave(8'($urandom_range(1, 254)));
        run_random(16, 16, 30, 1'b0);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
